// ----- rtl/core/seven_segment_frame_builder_defines.svh -----
// ----------------------------------------------------------------------------
// Seven-segment frame builder assertion macros
// Concurrent check wrappers clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SSFB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define SSFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSFB_ASSERT_IMPLY(label, ante, cons, msg)
`define SSFB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ssfb_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame builder package
// Shared types, command bytes and the segment decode table.
// ----------------------------------------------------------------------------
package ssfb_pkg;

  // action codes
  typedef enum logic [1:0] {
    ACT_DISPLAY = 2'd0,
    ACT_BRIGHT  = 2'd1,
    ACT_SINGLE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // controller command bytes
  localparam logic [7:0] CMD_AUTO_INC   = 8'h40;
  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE  = 8'hc0;
  localparam logic [7:0] CMD_DISP_CTRL  = 8'h88;
  localparam logic [7:0] GRID_ONE_FORCE = 8'h20;
  localparam logic [7:0] POINT_BIT      = 8'h80;

  // colon select codes
  localparam logic [2:0] COLON_DIG3 = 3'd2;
  localparam logic [2:0] COLON_DIG4 = 3'd1;
  localparam logic [2:0] COLON_DIG5 = 3'd4;

  // byte positions inside a frame
  localparam logic [2:0] POS_CMD   = 3'd0;
  localparam logic [2:0] POS_ADDR  = 3'd1;
  localparam logic [2:0] POS_GRID1 = 3'd2;
  localparam logic [2:0] POS_DIG2  = 3'd3;
  localparam logic [2:0] POS_DIG3  = 3'd4;
  localparam logic [2:0] POS_DIG4  = 3'd5;
  localparam logic [2:0] POS_DIG5  = 3'd6;
  localparam logic [2:0] POS_DIG6  = 3'd7;

  // last byte position per action
  localparam logic [2:0] LAST_DISPLAY = POS_DIG6;
  localparam logic [2:0] LAST_BRIGHT  = POS_CMD;
  localparam logic [2:0] LAST_SINGLE  = POS_GRID1;

  localparam int SEG_COUNT = 28;

  localparam logic [7:0] SEG_ROM [SEG_COUNT] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
    8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h00, 8'h37, 8'h78,
    8'h38, 8'h76, 8'h50, 8'h5c, 8'h73, 8'h3e, 8'h5c, 8'h0e
  };

  // one input item
  typedef struct packed {
    action_t    action;
    logic [7:0] group_one_bits;
    logic [2:0] colon_select;
    logic [4:0] digit_two;
    logic [4:0] digit_three;
    logic [4:0] digit_four;
    logic [4:0] digit_five;
    logic [4:0] digit_six;
    logic [2:0] brightness_level;
    logic [7:0] single_byte;
  } item_t;

  // one output byte with its bus markers
  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } beat_t;

  // digit code to segment pattern, blank above the table
  function automatic logic [7:0] seg_decode(input logic [4:0] code, input logic point);
    logic [7:0] v;
    v = 8'h00;
    if (code < 5'(SEG_COUNT)) begin
      v = SEG_ROM[code];
    end
    if (point) begin
      v = v | POINT_BIT;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/ssfb_frame_sel.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame byte select
// Picks the byte and bus markers at one frame position for a held item.
// ----------------------------------------------------------------------------
module ssfb_frame_sel
  import ssfb_pkg::*;
(
  input  item_t      item,
  input  logic [2:0] pos,
  output beat_t      beat,
  output logic [2:0] last_pos
);

  // last position of the frame for this action
  always_comb begin
    unique case (item.action)
      ACT_DISPLAY: last_pos = LAST_DISPLAY;
      ACT_BRIGHT:  last_pos = LAST_BRIGHT;
      ACT_SINGLE:  last_pos = LAST_SINGLE;
      default:     last_pos = POS_CMD;
    endcase
  end

  // byte at the current position
  always_comb begin
    beat = '0;
    unique case (item.action)
      ACT_DISPLAY: begin
        unique case (pos)
          POS_CMD:   beat = '{CMD_AUTO_INC, 1'b1, 1'b1, 1'b0};
          POS_ADDR:  beat = '{CMD_ADDR_BASE, 1'b1, 1'b0, 1'b0};
          POS_GRID1: beat = '{item.group_one_bits | GRID_ONE_FORCE, 1'b0, 1'b0, 1'b0};
          POS_DIG2:  beat = '{seg_decode(item.digit_two, 1'b0), 1'b0, 1'b0, 1'b0};
          POS_DIG3:  beat = '{seg_decode(item.digit_three, item.colon_select == COLON_DIG3),
                             1'b0, 1'b0, 1'b0};
          POS_DIG4:  beat = '{seg_decode(item.digit_four, item.colon_select == COLON_DIG4),
                             1'b0, 1'b0, 1'b0};
          POS_DIG5:  beat = '{seg_decode(item.digit_five, item.colon_select == COLON_DIG5),
                             1'b0, 1'b0, 1'b0};
          default:   beat = '{seg_decode(item.digit_six, 1'b0), 1'b0, 1'b1, 1'b1};
        endcase
      end
      ACT_BRIGHT: begin
        beat = '{CMD_DISP_CTRL | {5'd0, item.brightness_level}, 1'b1, 1'b1, 1'b1};
      end
      ACT_SINGLE: begin
        unique case (pos)
          POS_CMD:  beat = '{CMD_FIXED_ADDR, 1'b1, 1'b1, 1'b0};
          POS_ADDR: beat = '{CMD_ADDR_BASE, 1'b1, 1'b0, 1'b0};
          default:  beat = '{item.single_byte, 1'b0, 1'b1, 1'b1};
        endcase
      end
      default: beat = '0;
    endcase
  end

endmodule

// ----- rtl/core/seven_segment_frame_builder.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame builder
// Turns display actions into command byte frames for a two-wire controller.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: action; tdata: item fields
//  m_axis    out        tdata: bus byte; tuser: start/stop; tlast: frame end
//
//  One byte leaves per cycle while m_axis is not stalled; the byte counter
//  sets 8 bytes for a display write, 1 for brightness and 3 for a single byte.
//  An unused action is taken without the block going busy and gives no bytes.
//  The next item is taken in the cycle its predecessor's last byte is loaded.
//  rst clears the item and output valid flags; payload is not reset.
//  A stall on m_axis holds the output register and the byte counter.
// ----------------------------------------------------------------------------
`include "seven_segment_frame_builder_defines.svh"

module seven_segment_frame_builder
  import ssfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] group_one_bits, [10:8] colon_select, [15:11] digit_two,
  // [20:16] digit_three, [25:21] digit_four, [30:26] digit_five,
  // [35:31] digit_six, [38:36] brightness_level, [46:39] single_byte, [47] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] bus_byte
  output logic [7:0]  m_axis_tdata,
  // [0] start_before, [1] stop_after
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  item_t      in_item;
  item_t      item;
  logic       busy;
  logic [2:0] pos;
  beat_t      beat;
  logic [2:0] last_pos;
  logic       out_load;
  logic       finishing;
  logic       accept;

  // unpack the input transaction
  assign in_item.action           = action_t'(s_axis_tuser);
  assign in_item.group_one_bits   = s_axis_tdata[7:0];
  assign in_item.colon_select     = s_axis_tdata[10:8];
  assign in_item.digit_two        = s_axis_tdata[15:11];
  assign in_item.digit_three      = s_axis_tdata[20:16];
  assign in_item.digit_four       = s_axis_tdata[25:21];
  assign in_item.digit_five       = s_axis_tdata[30:26];
  assign in_item.digit_six        = s_axis_tdata[35:31];
  assign in_item.brightness_level = s_axis_tdata[38:36];
  assign in_item.single_byte      = s_axis_tdata[46:39];

  // byte selection for the held item
  ssfb_frame_sel u_frame_sel (
    .item     (item),
    .pos      (pos),
    .beat     (beat),
    .last_pos (last_pos)
  );

  // handshake control
  assign out_load      = busy && (!m_axis_tvalid || m_axis_tready);
  assign finishing     = out_load && (pos == last_pos);
  assign s_axis_tready = !busy || finishing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // item register and byte counter
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_CMD;
    end else if (accept) begin
      busy <= (in_item.action != ACT_NONE);
      pos  <= POS_CMD;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (out_load) begin
      pos <= pos + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= beat.bus_byte;
      m_axis_tuser <= {beat.stop_after, beat.start_before};
      m_axis_tlast <= beat.last;
    end
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // checks
  `SSFB_ASSERT_IMPLY(a_pos_in_frame, busy, pos <= last_pos, "byte counter past frame end")
  `SSFB_ASSERT_IMPLY(a_ready_when_busy, busy && s_axis_tready, finishing, "item taken mid frame")
  `SSFB_ASSERT_IMPLY(a_last_has_stop, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1], "frame end without stop")
  `SSFB_ASSERT_NEXT(a_finish_shows_last, finishing, m_axis_tvalid && m_axis_tlast, "last byte not flagged")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame builder testbench
// Drives display, brightness, single byte and unused actions through the
// input stream and checks every output byte and its start, stop and frame end
// markers against a predicted byte queue. Both sides idle at random, and the
// output side holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import ssfb_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int STEADY_ITEMS = 60;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  // predicted byte stream for the display controller
  class frame_checker;
    beat_t pending_bytes[$];
    int    errors;
    int    bytes_checked;
    int    actions_seen[4];

    function automatic logic [7:0] segments(logic [4:0] code, logic point);
      logic [7:0] pattern;
      pattern = 8'h00;
      if (code < SEG_COUNT) begin
        pattern = SEG_ROM[code];
      end
      if (point) begin
        pattern = pattern | POINT_BIT;
      end
      return pattern;
    endfunction

    function void add_byte(logic [7:0] data, logic st, logic sp, logic ls);
      beat_t b;
      b.bus_byte     = data;
      b.start_before = st;
      b.stop_after   = sp;
      b.last         = ls;
      pending_bytes.push_back(b);
    endfunction

    // work out the frame one accepted item causes
    function void note_item(item_t it);
      actions_seen[it.action]++;
      case (it.action)
        ACT_DISPLAY: begin
          add_byte(CMD_AUTO_INC, 1'b1, 1'b1, 1'b0);
          add_byte(CMD_ADDR_BASE, 1'b1, 1'b0, 1'b0);
          add_byte(it.group_one_bits | GRID_ONE_FORCE, 1'b0, 1'b0, 1'b0);
          add_byte(segments(it.digit_two, 1'b0), 1'b0, 1'b0, 1'b0);
          add_byte(segments(it.digit_three, it.colon_select == COLON_DIG3),
                   1'b0, 1'b0, 1'b0);
          add_byte(segments(it.digit_four, it.colon_select == COLON_DIG4),
                   1'b0, 1'b0, 1'b0);
          add_byte(segments(it.digit_five, it.colon_select == COLON_DIG5),
                   1'b0, 1'b0, 1'b0);
          add_byte(segments(it.digit_six, 1'b0), 1'b0, 1'b1, 1'b1);
        end
        ACT_BRIGHT: begin
          add_byte(CMD_DISP_CTRL | {5'd0, it.brightness_level}, 1'b1, 1'b1, 1'b1);
        end
        ACT_SINGLE: begin
          add_byte(CMD_FIXED_ADDR, 1'b1, 1'b1, 1'b0);
          add_byte(CMD_ADDR_BASE, 1'b1, 1'b0, 1'b0);
          add_byte(it.single_byte, 1'b0, 1'b1, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    // compare one output transaction with the oldest predicted byte
    function void check_byte(logic [7:0] data, logic [1:0] flags, logic lst);
      beat_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h flags %b last %b", $time, data, flags, lst);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (data !== want.bus_byte) begin
        $display("%0t: bus_byte expected %h actual %h", $time, want.bus_byte, data);
        errors++;
      end
      if (flags[0] !== want.start_before) begin
        $display("%0t: start_before expected %b actual %b", $time,
                 want.start_before, flags[0]);
        errors++;
      end
      if (flags[1] !== want.stop_after) begin
        $display("%0t: stop_after expected %b actual %b", $time,
                 want.stop_after, flags[1]);
        errors++;
      end
      if (lst !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [7:0] group_one_bits, [10:8] colon_select, [15:11] digit_two,
  // [20:16] digit_three, [25:21] digit_four, [30:26] digit_five,
  // [35:31] digit_six, [38:36] brightness_level, [46:39] single_byte, [47] zero
  logic [47:0] s_axis_tdata;
  // [1:0] action
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] bus_byte
  logic [7:0]  m_axis_tdata;
  // [0] start_before, [1] stop_after
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  frame_checker board = new();
  int   cycles;
  int   items_sent;
  bit   steady;
  bit   long_hold_done;

  seven_segment_frame_builder u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // output side ready: random stalls, one long hold-off
  initial begin : sink_ready
    int run_len;
    int hold_len;
    m_axis_tready <= 1'b1;
    forever begin
      run_len = $urandom_range(1, 30);
      repeat (run_len) @(posedge clk);
      if (!steady) begin
        if (!long_hold_done && items_sent >= 120) begin
          hold_len       = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          hold_len = $urandom_range(1, 18);
        end
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // random item with biased action and colon codes
  task automatic fill_random(output item_t it);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      it.action = ACT_DISPLAY;
    end else if (pick < 13) begin
      it.action = ACT_BRIGHT;
    end else if (pick < 18) begin
      it.action = ACT_SINGLE;
    end else begin
      it.action = ACT_NONE;
    end
    it.group_one_bits = 8'($urandom);
    case ($urandom_range(0, 5))
      0:       it.colon_select = COLON_DIG3;
      1:       it.colon_select = COLON_DIG4;
      2:       it.colon_select = COLON_DIG5;
      default: it.colon_select = 3'($urandom);
    endcase
    it.digit_two        = 5'($urandom);
    it.digit_three      = 5'($urandom);
    it.digit_four       = 5'($urandom);
    it.digit_five       = 5'($urandom);
    it.digit_six        = 5'($urandom);
    it.brightness_level = 3'($urandom);
    it.single_byte      = 8'($urandom);
  endtask

  // offer one item and hold it until the block takes it
  task automatic offer(input item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {1'b0, it.single_byte, it.brightness_level, it.digit_six,
                      it.digit_five, it.digit_four, it.digit_three, it.digit_two,
                      it.colon_select, it.group_one_bits};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(it);
    items_sent++;
  endtask

  // random input gap, junk on the bus while idle
  task automatic maybe_idle();
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 48'({$urandom, $urandom});
      s_axis_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // stimulus and end of run
  initial begin : stimulus
    item_t it;
    int    counted;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // display writes: every digit code, every colon code, grid one extremes
    for (int k = 0; k < 8; k++) begin
      fill_random(it);
      it.action         = ACT_DISPLAY;
      it.group_one_bits = (k == 0) ? 8'h00 : (k == 1) ? 8'hff :
                          (k == 2) ? GRID_ONE_FORCE : it.group_one_bits;
      it.colon_select   = 3'(k);
      it.digit_two      = 5'(5 * k);
      it.digit_three    = 5'(5 * k + 1);
      it.digit_four     = 5'(5 * k + 2);
      it.digit_five     = 5'(5 * k + 3);
      it.digit_six      = 5'(5 * k + 4);
      offer(it);
    end
    // blank digits above the table, point on a blank
    fill_random(it);
    it.action       = ACT_DISPLAY;
    it.colon_select = COLON_DIG3;
    it.digit_two    = 5'd28;
    it.digit_three  = 5'd29;
    it.digit_four   = 5'd30;
    it.digit_five   = 5'd31;
    it.digit_six    = 5'd28;
    offer(it);
    // brightness extremes
    for (int k = 0; k < 3; k++) begin
      fill_random(it);
      it.action           = ACT_BRIGHT;
      it.brightness_level = (k == 0) ? 3'd0 : (k == 1) ? 3'd7 : 3'd3;
      offer(it);
    end
    // single byte extremes
    for (int k = 0; k < 3; k++) begin
      fill_random(it);
      it.action      = ACT_SINGLE;
      it.single_byte = (k == 0) ? 8'h00 : (k == 1) ? 8'hff : 8'h5a;
      offer(it);
    end
    // unused action is dropped
    for (int k = 0; k < 2; k++) begin
      fill_random(it);
      it.action = ACT_NONE;
      offer(it);
    end

    // random traffic, calm at the end
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= RANDOM_ITEMS - STEADY_ITEMS) begin
        steady = 1'b1;
      end
      maybe_idle();
      fill_random(it);
      offer(it);
      if (it.action != ACT_NONE) begin
        counted++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d display writes, %0d brightness, %0d single writes,",
             board.actions_seen[ACT_DISPLAY], board.actions_seen[ACT_BRIGHT],
             board.actions_seen[ACT_SINGLE]);
    $display("%0d unused actions; %0d bytes checked, long output hold-off %0s",
             board.actions_seen[ACT_NONE], board.bytes_checked,
             long_hold_done ? "done" : "missed");
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
